// ===== rtl/sgcic_pkg.sv =====
package sgcic_pkg;

	localparam int RANGE_GATES_DEFAULT = 128;
	localparam int ANGLE_BINS_DEFAULT = 64;

	// Column blanking threshold is floor(33 * gates / 100).
	localparam int THRESH_NUM = 33;
	localparam int THRESH_W = 7;
	localparam int GATES_W = 8;
	// Division by 100 done as a multiply by 5243 / 2^19, exact for 33 * gates <= 8415.
	localparam int RECIP_MUL = 5243;
	localparam int RECIP_SHIFT = 19;

	localparam int GATES_RESET = 128;
	localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'((THRESH_NUM * GATES_RESET) / 100);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef enum logic {
		ACT_WRITE = 1'b0,
		ACT_READ  = 1'b1
	} action_t;

endpackage

// ===== rtl/sparse_grid_column_and_isolated_cleanup.sv =====
// Sparse radar grid cleanup filter.
// Input channel (in_valid / in_stall) carries one word per item: a write stores a cell
// into the range-by-angle grid and updates its column valid count; a read returns the
// filtered cell on the output channel (out_valid / out_stall).  Writes give no result.
// For each item, the accept cycle issues the synchronous memory reads, and
// the next cycle does the column read-modify-write or builds the result.  No new item is
// accepted until the previous one is done, so the column memory serves one item at a time.
// A read result is registered at the end of its execute step.  If that output register
// still holds an untaken result, the read waits in its execute step until the receiver
// takes it; a new item can still be accepted while a result sits in the output register.
// After reset the column memory is swept to all invalid, one angle column per cycle, so
// in_stall stays high until the sweep is done.  Configuration writes are taken at any time
// and set the blanking threshold floor(33 * range_gates_in_use / 100).
module sparse_grid_column_and_isolated_cleanup #(
	parameter int RANGE_GATES = sgcic_pkg::RANGE_GATES_DEFAULT,
	parameter int ANGLE_BINS = sgcic_pkg::ANGLE_BINS_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  logic [sgcic_pkg::GATES_W-1:0]    cfg_write_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             action,
	input  logic [6:0]                       range_index,
	input  logic [5:0]                       angle_index,
	input  logic                             cell_present,
	input  logic [31:0]                      power_in,
	input  logic signed [31:0]               velocity_in,
	input  logic [31:0]                      width_in,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             cell_valid,
	output logic [31:0]                      power_out,
	output logic signed [31:0]               velocity_out,
	output logic [31:0]                      width_out,
	output logic                             column_blanked
);

	localparam int RW = $clog2(RANGE_GATES);
	localparam int AW = (ANGLE_BINS > 1) ? $clog2(ANGLE_BINS) : 1;
	localparam int CAW = $clog2(RANGE_GATES * ANGLE_BINS);
	localparam int CW = $clog2(RANGE_GATES + 1);
	localparam int COLW = CW + RANGE_GATES;
	localparam logic [AW-1:0] LAST_ROW = AW'(ANGLE_BINS - 1);
	localparam logic [RW-1:0] LAST_GATE = RW'(RANGE_GATES - 1);

	sgcic_pkg::state_t state_q, state_d;

	// Column word: valid count in the top bits, one valid bit per range gate below.
	logic [COLW-1:0] col_mem [ANGLE_BINS];
	logic [95:0]     cell_mem [RANGE_GATES * ANGLE_BINS];

	logic [COLW-1:0] col_rd_s1;
	logic [95:0]     cell_rd_s1;
	logic            act_s1;
	logic            present_s1;
	logic            in_range_s1;
	logic [RW-1:0]   r_s1;
	logic [AW-1:0]   a_s1;

	logic [AW-1:0]   clr_q;
	logic [sgcic_pkg::THRESH_W-1:0] thresh_q;

	logic            out_valid_q;
	logic            cell_valid_q;
	logic            blanked_q;
	logic [31:0]     power_q;
	logic [31:0]     velocity_q;
	logic [31:0]     width_q;

	logic            accept;
	logic            in_range;
	logic [15:0]     r_ext;
	logic [15:0]     a_ext;
	logic [RW-1:0]   r_addr;
	logic [AW-1:0]   a_addr;
	logic [CAW-1:0]  cell_addr;

	logic            col_we;
	logic [AW-1:0]   col_waddr;
	logic [COLW-1:0] col_wdata;
	logic            out_load;

	logic [RANGE_GATES-1:0] bits_s1;
	logic [RANGE_GATES-1:0] new_bits;
	logic [CW-1:0]          count_s1;
	logic [CW-1:0]          new_count;
	logic                   old_bit;
	logic                   blanked;
	logic                   interior;
	logic                   isolated;
	logic                   valid_res;

	logic [13:0]     gates_x33;
	logic [25:0]     thresh_prod;

	assign r_ext = {9'd0, range_index};
	assign a_ext = {10'd0, angle_index};
	assign r_addr = r_ext[RW-1:0];
	assign a_addr = a_ext[AW-1:0];
	assign in_range = (32'(r_ext) < 32'(RANGE_GATES)) && (32'(a_ext) < 32'(ANGLE_BINS));
	assign cell_addr = CAW'(32'(a_ext) * 32'(RANGE_GATES) + 32'(r_ext));

	assign accept = in_valid && !in_stall;

	// Threshold is computed from the write data and registered on each configuration write.
	assign gates_x33 = 14'(cfg_write_data) * 14'(sgcic_pkg::THRESH_NUM);
	assign thresh_prod = 26'(gates_x33) * 26'(sgcic_pkg::RECIP_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= sgcic_pkg::THRESH_RESET;
		end else if (cfg_write_en) begin
			thresh_q <= sgcic_pkg::THRESH_W'(thresh_prod >> sgcic_pkg::RECIP_SHIFT);
		end
	end

	// Column word decode and update.
	always_comb begin
		bits_s1 = col_rd_s1[RANGE_GATES-1:0];
		count_s1 = col_rd_s1[COLW-1:RANGE_GATES];
		old_bit = bits_s1[r_s1];
		new_bits = bits_s1;
		new_bits[r_s1] = present_s1;
		new_count = count_s1;
		if (present_s1 && !old_bit) begin
			new_count = count_s1 + 1'b1;
		end else if (!present_s1 && old_bit) begin
			new_count = count_s1 - 1'b1;
		end
		blanked = 16'(count_s1) >= 16'(thresh_q);
		interior = (r_s1 != '0) && (r_s1 != LAST_GATE);
		isolated = interior && !bits_s1[r_s1 - 1'b1] && !bits_s1[r_s1 + 1'b1];
		valid_res = in_range_s1 && old_bit && !blanked && !isolated;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sgcic_pkg::ST_CLEAR;
			clr_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == sgcic_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		col_we = 1'b0;
		col_waddr = a_s1;
		col_wdata = {new_count, new_bits};
		out_load = 1'b0;
		unique case (state_q)
			sgcic_pkg::ST_CLEAR: begin
				col_we = 1'b1;
				col_waddr = clr_q;
				col_wdata = '0;
				if (clr_q == LAST_ROW) begin
					state_d = sgcic_pkg::ST_IDLE;
				end
			end
			sgcic_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = sgcic_pkg::ST_EXEC;
				end
			end
			sgcic_pkg::ST_EXEC: begin
				if (act_s1 == sgcic_pkg::ACT_WRITE) begin
					col_we = in_range_s1;
					state_d = sgcic_pkg::ST_IDLE;
				end else if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d = sgcic_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sgcic_pkg::ST_IDLE;
			end
		endcase
	end

	// Column memory: one read at accept, one write per column update or clear step.
	always_ff @(posedge clk) begin
		if (accept) begin
			col_rd_s1 <= col_mem[a_addr];
		end
		if (col_we) begin
			col_mem[col_waddr] <= col_wdata;
		end
	end

	// Cell memory: data is written straight at accept; a bad cell keeps its old values.
	always_ff @(posedge clk) begin
		if (accept && action == sgcic_pkg::ACT_READ) begin
			cell_rd_s1 <= cell_mem[cell_addr];
		end
		if (accept && action == sgcic_pkg::ACT_WRITE && in_range && cell_present) begin
			cell_mem[cell_addr] <= {power_in, velocity_in, width_in};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1 <= action;
			present_s1 <= cell_present;
			in_range_s1 <= in_range;
			r_s1 <= r_addr;
			a_s1 <= a_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			cell_valid_q <= valid_res;
			blanked_q <= in_range_s1 && blanked;
			power_q <= valid_res ? cell_rd_s1[95:64] : 32'd0;
			velocity_q <= valid_res ? cell_rd_s1[63:32] : 32'd0;
			width_q <= valid_res ? cell_rd_s1[31:0] : 32'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign cell_valid = cell_valid_q;
	assign column_blanked = blanked_q;
	assign power_out = power_q;
	assign velocity_out = $signed(velocity_q);
	assign width_out = width_q;

`ifndef SYNTHESIS
	// Every item owns the memories until its execute step is done.
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("item accepted while previous item still in flight");

	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == sgcic_pkg::ST_EXEC && act_s1))
		else $error("result produced without a read item");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sgcic_pkg::ST_EXEC && col_we) |-> (32'(new_count) <= 32'(RANGE_GATES)))
		else $error("column valid count out of range");

	a_read_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sgcic_pkg::ST_EXEC && act_s1 && out_valid_q && out_stall)
		|=> (state_q == sgcic_pkg::ST_EXEC))
		else $error("read result dropped while output register was full");
`endif

endmodule

// ===== tb/sgcic_checker.sv =====
`timescale 1ns / 1ps

module sgcic_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic [sgcic_pkg::GATES_W-1:0] cfg_write_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic                          action,
	input  logic [6:0]                    range_index,
	input  logic [5:0]                    angle_index,
	input  logic                          cell_present,
	input  logic [31:0]                   power_in,
	input  logic signed [31:0]            velocity_in,
	input  logic [31:0]                   width_in,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic                          cell_valid,
	input  logic [31:0]                   power_out,
	input  logic signed [31:0]            velocity_out,
	input  logic [31:0]                   width_out,
	input  logic                          column_blanked,
	output int                            fail_count,
	output int                            pending,
	output int                            n_writes,
	output int                            n_reads,
	output int                            n_kept,
	output int                            n_blanked,
	output int                            n_isolated
);

	localparam int GATES = sgcic_pkg::RANGE_GATES_DEFAULT;
	localparam int ANGLES = sgcic_pkg::ANGLE_BINS_DEFAULT;
	localparam int GW = sgcic_pkg::GATES_W;
	localparam int PRINT_CAP = 30;

	typedef struct packed {
		logic        keep;
		logic [31:0] power;
		logic [31:0] velocity;
		logic [31:0] width;
		logic        blanked;
	} cell_result_t;

	cell_result_t expected_cells [$];

	logic [31:0] power_mem [ANGLES][GATES];
	logic [31:0] velocity_mem [ANGLES][GATES];
	logic [31:0] width_mem [ANGLES][GATES];
	bit present_map [ANGLES][GATES];
	int present_count [ANGLES];
	logic [GW-1:0] gates_in_use = GW'(sgcic_pkg::GATES_RESET);

	int mismatches = 0;
	int results_seen = 0;
	int writes_seen = 0;
	int reads_seen = 0;
	int kept_seen = 0;
	int blanked_seen = 0;
	int isolated_seen = 0;

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("mismatch at %0t, result word %0d: %s", $realtime, results_seen, msg);
	endtask

	// Filtered view of one cell under the current gate count.
	function automatic cell_result_t filter_cell(input int r, input int a);
		cell_result_t res;
		int thresh;
		bit keep;
		res = '0;
		thresh = (sgcic_pkg::THRESH_NUM * int'(gates_in_use)) / 100;
		res.blanked = present_count[a] >= thresh;
		keep = present_map[a][r] && !res.blanked;
		// An interior gate survives only with at least one valid neighbour in its column.
		if (keep && r >= 1 && r + 1 < GATES && !present_map[a][r - 1] && !present_map[a][r + 1])
			keep = 1'b0;
		if (keep) begin
			res.keep = 1'b1;
			res.power = power_mem[a][r];
			res.velocity = velocity_mem[a][r];
			res.width = width_mem[a][r];
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cell_result_t want;
		int r;
		int a;
		if (!arst_n) begin
			for (int i = 0; i < ANGLES; i++) begin
				present_count[i] = 0;
				for (int j = 0; j < GATES; j++)
					present_map[i][j] = 1'b0;
			end
			gates_in_use = GW'(sgcic_pkg::GATES_RESET);
			expected_cells.delete();
		end else begin
			if (cfg_write_en)
				gates_in_use = cfg_write_data;
			if (in_valid && !in_stall) begin
				r = int'(range_index);
				a = int'(angle_index);
				if (action == sgcic_pkg::ACT_WRITE) begin
					writes_seen++;
					// A bad cell keeps whatever values it held before.
					if (cell_present) begin
						power_mem[a][r] = power_in;
						velocity_mem[a][r] = velocity_in;
						width_mem[a][r] = width_in;
					end
					if (cell_present && !present_map[a][r])
						present_count[a]++;
					else if (!cell_present && present_map[a][r])
						present_count[a]--;
					present_map[a][r] = cell_present;
				end else begin
					reads_seen++;
					want = filter_cell(r, a);
					if (want.keep)
						kept_seen++;
					if (want.blanked)
						blanked_seen++;
					if (present_map[a][r] && !want.blanked && !want.keep)
						isolated_seen++;
					expected_cells.push_back(want);
				end
			end
			if (out_valid && !out_stall) begin
				if (expected_cells.size() == 0) begin
					report_mismatch("result word arrived with nothing expected");
				end else begin
					want = expected_cells.pop_front();
					if (cell_valid !== want.keep)
						report_mismatch($sformatf("cell_valid %b, expected %b",
							cell_valid, want.keep));
					if (power_out !== want.power)
						report_mismatch($sformatf("power_out %h, expected %h",
							power_out, want.power));
					if (velocity_out !== want.velocity)
						report_mismatch($sformatf("velocity_out %h, expected %h",
							velocity_out, want.velocity));
					if (width_out !== want.width)
						report_mismatch($sformatf("width_out %h, expected %h",
							width_out, want.width));
					if (column_blanked !== want.blanked)
						report_mismatch($sformatf("column_blanked %b, expected %b",
							column_blanked, want.blanked));
				end
				results_seen++;
			end
		end
		fail_count <= mismatches;
		pending <= expected_cells.size();
		n_writes <= writes_seen;
		n_reads <= reads_seen;
		n_kept <= kept_seen;
		n_blanked <= blanked_seen;
		n_isolated <= isolated_seen;
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int LIMIT = 600000;
	localparam int NPHASES = 10;
	localparam int ITEMS_PER_PHASE = 112;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE = 8;
	localparam int DRAIN = 20;
	localparam int PRESSURE_PHASE = 3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write_en = 1'b0;
	logic [sgcic_pkg::GATES_W-1:0] cfg_write_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = 1'b0;
	logic [6:0] range_index = '0;
	logic [5:0] angle_index = '0;
	logic cell_present = 1'b0;
	logic [31:0] power_in = '0;
	logic signed [31:0] velocity_in = '0;
	logic [31:0] width_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic cell_valid;
	logic [31:0] power_out;
	logic signed [31:0] velocity_out;
	logic [31:0] width_out;
	logic column_blanked;

	int fail_count;
	int pending;
	int n_writes;
	int n_reads;
	int n_kept;
	int n_blanked;
	int n_isolated;

	bit no_gaps = 1'b0;
	int squeeze_asks = 0;
	int cycles = 0;

	// Cells that have received values at least once; only these are ever read.
	bit has_data [64][128];
	int unsigned filled_q [$];
	int unsigned recent_q [$];
	int pool [3];
	int window_lo;
	int window_w;
	int present_pct;
	int read_pct;

	sparse_grid_column_and_isolated_cleanup uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.range_index    (range_index),
		.angle_index    (angle_index),
		.cell_present   (cell_present),
		.power_in       (power_in),
		.velocity_in    (velocity_in),
		.width_in       (width_in),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.cell_valid     (cell_valid),
		.power_out      (power_out),
		.velocity_out   (velocity_out),
		.width_out      (width_out),
		.column_blanked (column_blanked)
	);

	sgcic_checker grid_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.range_index    (range_index),
		.angle_index    (angle_index),
		.cell_present   (cell_present),
		.power_in       (power_in),
		.velocity_in    (velocity_in),
		.width_in       (width_in),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.cell_valid     (cell_valid),
		.power_out      (power_out),
		.velocity_out   (velocity_out),
		.width_out      (width_out),
		.column_blanked (column_blanked),
		.fail_count     (fail_count),
		.pending        (pending),
		.n_writes       (n_writes),
		.n_reads        (n_reads),
		.n_kept         (n_kept),
		.n_blanked      (n_blanked),
		.n_isolated     (n_isolated)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[sparse_grid_column_and_isolated_cleanup] ERROR");
		$finish;
	end

	function automatic int pick_gap();
		int roll;
		if (no_gaps)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [sgcic_pkg::GATES_W-1:0] gate_setting(input int ph);
		case (ph)
			0: return 8'd128;
			1: return 8'd0;
			2: return 8'd3;
			3: return 8'd4;
			4: return 8'd7;
			5: return 8'd20;
			6: return 8'd50;
			7: return 8'd100;
			8: return 8'd127;
			default: return 8'd128;
		endcase
	endfunction

	// Offers one word and returns at the edge where it is taken; valid stays high
	// so that a following word can go out back to back.
	task automatic send_word(input sgcic_pkg::action_t act, input int r, input int a,
			input bit p, input logic [31:0] pw, input logic [31:0] vel, input logic [31:0] wd);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		range_index <= 7'(r);
		angle_index <= 6'(a);
		cell_present <= p;
		power_in <= pw;
		velocity_in <= vel;
		width_in <= wd;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_cell(input int r, input int a, input bit p,
			input logic [31:0] pw, input logic [31:0] vel, input logic [31:0] wd);
		send_word(sgcic_pkg::ACT_WRITE, r, a, p, pw, vel, wd);
		if (p) begin
			if (!has_data[a][r]) begin
				has_data[a][r] = 1'b1;
				filled_q.push_back(a * 128 + r);
			end
			recent_q.push_back(a * 128 + r);
			if (recent_q.size() > 24)
				void'(recent_q.pop_front());
		end
	endtask

	task automatic read_cell(input int r, input int a);
		send_word(sgcic_pkg::ACT_READ, r, a, 1'($urandom_range(0, 1)),
			$urandom(), $urandom(), $urandom());
	endtask

	task automatic random_word();
		int unsigned cell_id;
		int r;
		int a;
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < read_pct && filled_q.size() > 0) begin
			if (recent_q.size() > 0 && $urandom_range(0, 1))
				cell_id = recent_q[$urandom_range(0, recent_q.size() - 1)];
			else
				cell_id = filled_q[$urandom_range(0, filled_q.size() - 1)];
			a = cell_id / 128;
			r = cell_id % 128;
			// Step to a neighbour now and then, as long as it holds data.
			if ($urandom_range(0, 3) == 0) begin
				roll = $urandom_range(0, 1) ? r + 1 : r - 1;
				if (roll >= 0 && roll < 128 && has_data[a][roll])
					r = roll;
			end
			read_cell(r, a);
		end else begin
			roll = $urandom_range(0, 99);
			a = (roll < 85) ? pool[$urandom_range(0, 2)] : $urandom_range(0, 63);
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				r = window_lo + $urandom_range(0, window_w - 1);
			end else if (roll < 80) begin
				case ($urandom_range(0, 3))
					0: r = 0;
					1: r = 1;
					2: r = 126;
					default: r = 127;
				endcase
			end else begin
				r = $urandom_range(0, 127);
			end
			write_cell(r, a, $urandom_range(0, 99) < present_pct,
				$urandom(), $urandom(), $urandom());
		end
	endtask

	// Output side: random stalls, plus one long hold-off when asked for.
	initial begin : receiver
		int served;
		int len;
		served = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (squeeze_asks != served) begin
				served++;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				len = pick_gap();
				if (len > 0) begin
					out_stall <= 1'b1;
					repeat (len) @(posedge clk);
				end
				out_stall <= 1'b0;
				len = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
				repeat (len) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int ph = 0; ph < NPHASES; ph++) begin
			// No item is in flight here, so the gate count can change.
			cfg_write_en <= 1'b1;
			cfg_write_data <= gate_setting(ph);
			@(posedge clk);
			cfg_write_en <= 1'b0;
			for (int i = 0; i < 3; i++)
				pool[i] = $urandom_range(0, 7) * 9;
			window_w = $urandom_range(6, 24);
			window_lo = $urandom_range(0, 128 - window_w);
			present_pct = $urandom_range(30, 90);
			read_pct = (ph == PRESSURE_PHASE) ? 70 : $urandom_range(35, 60);
			no_gaps = (ph == 5);
			if (ph == 0) begin
				write_cell(0, 0, 1'b1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000);
				write_cell(1, 0, 1'b1, 32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
				read_cell(0, 0);
				read_cell(1, 0);
				// The last gate is kept even with an empty neighbour.
				write_cell(127, 0, 1'b1, 32'hA5A5_A5A5, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
				read_cell(127, 0);
				write_cell(60, 0, 1'b1, $urandom(), $urandom(), $urandom());
				read_cell(60, 0);
				write_cell(61, 0, 1'b1, $urandom(), $urandom(), $urandom());
				read_cell(60, 0);
				read_cell(61, 0);
				write_cell(61, 0, 1'b0, $urandom(), $urandom(), $urandom());
				read_cell(61, 0);
				read_cell(60, 0);
				write_cell(60, 0, 1'b1, $urandom(), $urandom(), $urandom());
				read_cell(60, 0);
				write_cell(127, 63, 1'b1, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
				write_cell(126, 63, 1'b1, $urandom(), $urandom(), $urandom());
				read_cell(127, 63);
				read_cell(126, 63);
				write_cell(0, 0, 1'b0, $urandom(), $urandom(), $urandom());
				read_cell(1, 0);
				read_cell(0, 0);
			end
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (ph == PRESSURE_PHASE && i == 30)
					squeeze_asks++;
				random_word();
			end
			in_valid <= 1'b0;
			do @(posedge clk); while (pending != 0);
			repeat (SETTLE) @(posedge clk);
		end
		no_gaps = 1'b0;
		repeat (DRAIN) @(posedge clk);
		$display("Run covered %0d cell writes and %0d reads over %0d gate-count settings.",
			n_writes, n_reads, NPHASES);
		$display("Reads gave %0d kept cells, %0d in blanked columns, %0d dropped as isolated.",
			n_kept, n_blanked, n_isolated);
		if (fail_count == 0 && pending == 0)
			$display("[sparse_grid_column_and_isolated_cleanup] OK");
		else
			$display("[sparse_grid_column_and_isolated_cleanup] ERROR");
		$finish;
	end

endmodule
